// File: src/touch_gesture_statistics_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the touch gesture statistics core.
// ---------------------------------------------------------------------------
`ifndef TOUCH_GESTURE_STATISTICS_CORE_DEFINES_SVH
`define TOUCH_GESTURE_STATISTICS_CORE_DEFINES_SVH

// A condition that must hold in the same cycle as its trigger.
`define TGS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define TGS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/tgs_pkg.sv
// ---------------------------------------------------------------------------
// tgs_pkg
// Types and constants shared by the touch gesture statistics core.
// ---------------------------------------------------------------------------
package tgs_pkg;

    // Operation codes of an input request.
    localparam logic [1:0] OP_FRAME = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Configuration register indexes.
    localparam int          CFG_IDX_W          = 2;
    localparam logic [1:0]  CFG_MOVE_THRESHOLD = 2'd0;
    localparam logic [1:0]  CFG_SHORT_FRAMES   = 2'd1;
    localparam logic [31:0] MOVE_THRESHOLD_RST = 32'd20000;
    localparam logic [15:0] SHORT_FRAMES_RST   = 16'd40;

    // Statistics counters.
    localparam int          NUM_BINS     = 5;
    localparam int          NUM_COUNTERS = 9;
    localparam int          IDX_PRESS    = 5;
    localparam int          IDX_SHORT    = 6;
    localparam int          IDX_LONG     = 7;
    localparam int          IDX_SLIDE    = 8;
    localparam logic [15:0] CNT_MAX      = 16'hFFFF;

    typedef enum logic [1:0] {
        K_FRAME,
        K_READ,
        K_CLEAR,
        K_NOP
    } t_kind;

    typedef enum logic [1:0] {
        CLS_NONE  = 2'd0,
        CLS_SLIDE = 2'd1,
        CLS_SHORT = 2'd2,
        CLS_LONG  = 2'd3
    } t_class;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] scan_time;
        logic        key_pressed;
        logic [7:0]  finger_count;
        logic [15:0] first_x;
        logic [15:0] first_y;
        logic [4:0]  contact_mask;
        logic [3:0]  counter_index;
    } t_in_item;

    typedef struct packed {
        logic [15:0] read_value;
        logic        frame_accepted;
        logic        gesture_end;
        logic [1:0]  gesture_class;
        logic [7:0]  peak_fingers;
        logic        overflow_alert;
    } t_result;

    // A classified request as it sits in the work queue.
    typedef struct packed {
        t_kind       kind;
        logic [15:0] scan_time;
        logic        key_pressed;
        logic [7:0]  finger_count;
        logic        one_finger;
        logic        all_up;
        logic [15:0] first_x;
        logic [15:0] first_y;
        logic        read_ok;
        logic [3:0]  counter_index;
    } t_work;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] index;
        logic [31:0]          data;
    } t_cfg_write;

    // Number of finger slots that take part in the all-up test and binning.
    function automatic int slot_count(input int max_fingers);
        return (max_fingers < NUM_BINS) ? max_fingers : NUM_BINS;
    endfunction

endpackage

// File: src/tgs_fifo.sv
// ---------------------------------------------------------------------------
// tgs_fifo
// Small register queue with push/full and pop/empty handshakes.
// ---------------------------------------------------------------------------
module tgs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: src/tgs_front.sv
// ---------------------------------------------------------------------------
// tgs_front
// Classifies an incoming request into the form the execution side uses.
// ---------------------------------------------------------------------------
module tgs_front #(
    parameter int MAX_FINGERS = 5
) (
    input  tgs_pkg::t_in_item i_item,
    output tgs_pkg::t_work    o_work
);
    localparam int         SLOT_COUNT = tgs_pkg::slot_count(MAX_FINGERS);
    localparam logic [4:0] SLOT_MASK  = 5'((1 << SLOT_COUNT) - 1);

    tgs_pkg::t_kind kind;

    always_comb begin
        unique case (i_item.operation)
            tgs_pkg::OP_FRAME: kind = tgs_pkg::K_FRAME;
            tgs_pkg::OP_READ:  kind = tgs_pkg::K_READ;
            tgs_pkg::OP_CLEAR: kind = tgs_pkg::K_CLEAR;
            default:           kind = tgs_pkg::K_NOP;
        endcase
    end

    always_comb begin
        o_work.kind          = kind;
        o_work.scan_time     = i_item.scan_time;
        o_work.key_pressed   = i_item.key_pressed;
        o_work.finger_count  = i_item.finger_count;
        o_work.one_finger    = (i_item.finger_count == 8'd1);
        // Only the slots that exist take part in the all-up test.
        o_work.all_up        = ((i_item.contact_mask & SLOT_MASK) == 5'd0);
        o_work.first_x       = i_item.first_x;
        o_work.first_y       = i_item.first_y;
        o_work.read_ok       = (i_item.counter_index < 4'(tgs_pkg::NUM_COUNTERS));
        o_work.counter_index = i_item.counter_index;
    end

endmodule

// File: src/tgs_back.sv
// ---------------------------------------------------------------------------
// tgs_back
// Execution side: distance squares in a prepare stage, then the gesture
// state and statistics counter update in an execute stage.
// ---------------------------------------------------------------------------
module tgs_back #(
    parameter int MAX_FINGERS = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tgs_pkg::t_cfg_write i_cfg,
    input  logic                i_work_empty,
    input  tgs_pkg::t_work      i_work,
    output logic                o_work_pop,
    input  logic                i_res_full,
    output logic                o_res_push,
    output tgs_pkg::t_result    o_res
);
    localparam int SLOT_COUNT = tgs_pkg::slot_count(MAX_FINGERS);
    localparam int NC         = tgs_pkg::NUM_COUNTERS;

    // Configuration.
    logic [31:0] r_move_thr;
    logic [15:0] r_short_frames;

    // Per-gesture state.
    logic [15:0] r_last_scan, n_last_scan;
    logic [15:0] r_frame_count, n_frame_count;
    logic        r_last_key, n_last_key;
    logic [7:0]  r_peak, n_peak;
    logic        r_single, n_single;
    logic        r_moved, n_moved;
    logic [15:0] r_origin_x, n_origin_x;
    logic [15:0] r_origin_y, n_origin_y;

    logic [15:0] r_cnt [NC];
    logic [15:0] n_cnt [NC];

    // Prepare-to-execute register.
    logic           r_p_valid;
    tgs_pkg::t_work r_p_work;
    logic [31:0]    r_p_sq_x, r_p_sq_y;

    logic           commit, load;
    logic [15:0]    ox, oy, dx, dy;
    logic [31:0]    n_sq_x, n_sq_y;

    logic           acc, gend, press, latch, check, hit;
    logic [15:0]    fc_inc;
    logic [7:0]     peak_n;
    logic           single_n, moved_n;
    logic [32:0]    sq_dist;
    tgs_pkg::t_class cls;
    logic [NC-1:0]  inc, at_top;
    logic [15:0]    rd_val;

    assign commit     = r_p_valid && !i_res_full;
    assign load       = !i_work_empty && (!r_p_valid || commit);
    assign o_work_pop = load;
    assign o_res_push = commit;

    // Execute stage decisions.
    always_comb begin
        acc      = (r_p_work.kind == tgs_pkg::K_FRAME) && (r_p_work.scan_time != r_last_scan);
        fc_inc   = (r_frame_count != tgs_pkg::CNT_MAX) ? r_frame_count + 16'd1 : r_frame_count;
        peak_n   = (r_p_work.finger_count > r_peak) ? r_p_work.finger_count : r_peak;
        single_n = r_single && r_p_work.one_finger;
        latch    = acc && single_n && (fc_inc == 16'd1);
        check    = acc && single_n && (fc_inc > 16'd1) && !r_moved;
        sq_dist  = {1'b0, r_p_sq_x} + {1'b0, r_p_sq_y};
        hit      = check && (sq_dist > {1'b0, r_move_thr});
        moved_n  = r_moved || hit;
        gend     = acc && r_p_work.all_up;
        press    = acc && !r_p_work.key_pressed && r_last_key;

        cls = tgs_pkg::CLS_NONE;
        if (gend && single_n) begin
            if (moved_n) begin
                cls = tgs_pkg::CLS_SLIDE;
            end else if (fc_inc < r_short_frames) begin
                cls = tgs_pkg::CLS_SHORT;
            end else begin
                cls = tgs_pkg::CLS_LONG;
            end
        end
    end

    // The origin a following frame measures against: a frame that latches
    // the origin in this cycle forwards its own coordinates.
    always_comb begin
        ox = (commit && latch) ? r_p_work.first_x : r_origin_x;
        oy = (commit && latch) ? r_p_work.first_y : r_origin_y;
        dx = (i_work.first_x >= ox) ? i_work.first_x - ox : ox - i_work.first_x;
        dy = (i_work.first_y >= oy) ? i_work.first_y - oy : oy - i_work.first_y;
        n_sq_x = 32'(dx) * 32'(dx);
        n_sq_y = 32'(dy) * 32'(dy);
    end

    // Counter increments; a peak outside the existing slots bins nothing.
    always_comb begin
        inc = '0;
        for (int i = 0; i < tgs_pkg::NUM_BINS; i++) begin
            inc[i] = gend && (peak_n == 8'(i + 1)) && (i < SLOT_COUNT);
        end
        inc[tgs_pkg::IDX_PRESS] = press;
        inc[tgs_pkg::IDX_SLIDE] = (cls == tgs_pkg::CLS_SLIDE);
        inc[tgs_pkg::IDX_SHORT] = (cls == tgs_pkg::CLS_SHORT);
        inc[tgs_pkg::IDX_LONG]  = (cls == tgs_pkg::CLS_LONG);

        for (int i = 0; i < NC; i++) begin
            at_top[i] = &r_cnt[i][15:1];
            if (r_p_work.kind == tgs_pkg::K_CLEAR) begin
                n_cnt[i] = '0;
            end else if (inc[i] && (r_cnt[i] != tgs_pkg::CNT_MAX)) begin
                n_cnt[i] = r_cnt[i] + 16'd1;
            end else begin
                n_cnt[i] = r_cnt[i];
            end
        end
    end

    always_comb begin
        rd_val = '0;
        if ((r_p_work.kind == tgs_pkg::K_READ) && r_p_work.read_ok) begin
            rd_val = r_cnt[r_p_work.counter_index];
        end
    end

    always_comb begin
        o_res.read_value     = rd_val;
        o_res.frame_accepted = acc;
        o_res.gesture_end    = gend;
        o_res.gesture_class  = 2'(cls);
        o_res.peak_fingers   = gend ? peak_n : 8'd0;
        o_res.overflow_alert = |(inc & at_top);
    end

    // Next gesture state; a closed gesture returns everything to reset.
    always_comb begin
        n_last_scan   = r_last_scan;
        n_frame_count = r_frame_count;
        n_last_key    = r_last_key;
        n_peak        = r_peak;
        n_single      = r_single;
        n_moved       = r_moved;
        n_origin_x    = r_origin_x;
        n_origin_y    = r_origin_y;
        if (gend) begin
            n_last_scan   = '0;
            n_frame_count = '0;
            n_last_key    = 1'b0;
            n_peak        = '0;
            n_single      = 1'b1;
            n_moved       = 1'b0;
            n_origin_x    = '0;
            n_origin_y    = '0;
        end else if (acc) begin
            n_last_scan   = r_p_work.scan_time;
            n_frame_count = fc_inc;
            n_last_key    = r_p_work.key_pressed;
            n_peak        = peak_n;
            n_single      = single_n;
            n_moved       = moved_n;
            if (latch) begin
                n_origin_x = r_p_work.first_x;
                n_origin_y = r_p_work.first_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_move_thr     <= tgs_pkg::MOVE_THRESHOLD_RST;
            r_short_frames <= tgs_pkg::SHORT_FRAMES_RST;
        end else if (i_cfg.we) begin
            unique case (i_cfg.index)
                tgs_pkg::CFG_MOVE_THRESHOLD: r_move_thr     <= i_cfg.data;
                tgs_pkg::CFG_SHORT_FRAMES:   r_short_frames <= i_cfg.data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid     <= 1'b0;
            r_last_scan   <= '0;
            r_frame_count <= '0;
            r_last_key    <= 1'b0;
            r_peak        <= '0;
            r_single      <= 1'b1;
            r_moved       <= 1'b0;
            r_origin_x    <= '0;
            r_origin_y    <= '0;
            for (int i = 0; i < NC; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            if (load) begin
                r_p_valid <= 1'b1;
            end else if (commit) begin
                r_p_valid <= 1'b0;
            end
            if (commit) begin
                r_last_scan   <= n_last_scan;
                r_frame_count <= n_frame_count;
                r_last_key    <= n_last_key;
                r_peak        <= n_peak;
                r_single      <= n_single;
                r_moved       <= n_moved;
                r_origin_x    <= n_origin_x;
                r_origin_y    <= n_origin_y;
                for (int i = 0; i < NC; i++) begin
                    r_cnt[i] <= n_cnt[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_p_work <= i_work;
            r_p_sq_x <= n_sq_x;
            r_p_sq_y <= n_sq_y;
        end
    end

endmodule

// File: src/touch_gesture_statistics_core.sv
// ---------------------------------------------------------------------------
// touch_gesture_statistics_core
// Touchpad gesture statistics: frame filtering, gesture classification and
// saturating usage counters with read and clear requests.
// ---------------------------------------------------------------------------
//  Channel   | Direction | Handshake                 | Payload
//  ----------+-----------+---------------------------+-----------------------
//  request   | in        | push / full               | i_item   (t_in_item)
//  result    | out       | empty / pop               | o_result (t_result)
//  config    | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One request is taken per cycle while the request queue is not full, and one
// result leaves per cycle while results are popped. A request passes through
// the request queue and the prepare register, whose execute logic writes the
// result queue. The execute stage holds the gesture state, so its update sets
// the sustained rate. Reset is synchronous and needs no clearing pass.
// A full result queue stalls execution; the request queue keeps taking
// requests until it fills.
// ---------------------------------------------------------------------------
`include "touch_gesture_statistics_core_defines.svh"

module touch_gesture_statistics_core #(
    parameter int MAX_FINGERS = 5,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  tgs_pkg::t_in_item                  i_item,
    output logic                               empty,
    input  logic                               pop,
    output tgs_pkg::t_result                   o_result,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tgs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [31:0]                        i_cfg_data
);
    localparam int WORK_W = $bits(tgs_pkg::t_work);
    localparam int RES_W  = $bits(tgs_pkg::t_result);

    tgs_pkg::t_work      w_front_work;
    tgs_pkg::t_work      w_queue_work;
    logic [WORK_W-1:0]   w_queue_data;
    logic                w_in_empty;
    logic                w_work_pop;
    logic                w_res_full;
    logic                w_res_push;
    tgs_pkg::t_result    w_res;
    logic [RES_W-1:0]    w_res_data;
    tgs_pkg::t_cfg_write w_cfg;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        w_cfg.we    = i_cfg_valid && o_cfg_ready;
        w_cfg.index = i_cfg_index;
        w_cfg.data  = i_cfg_data;
    end

    tgs_front #(
        .MAX_FINGERS(MAX_FINGERS)
    ) u_front (
        .i_item(i_item),
        .o_work(w_front_work)
    );

    tgs_fifo #(
        .WIDTH(WORK_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_work_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (w_front_work),
        .o_full (full),
        .i_pop  (w_work_pop),
        .o_data (w_queue_data),
        .o_empty(w_in_empty)
    );

    assign w_queue_work = tgs_pkg::t_work'(w_queue_data);

    tgs_back #(
        .MAX_FINGERS(MAX_FINGERS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_work_empty(w_in_empty),
        .i_work      (w_queue_work),
        .o_work_pop  (w_work_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res)
    );

    tgs_fifo #(
        .WIDTH(RES_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_result_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_res_push),
        .i_data (w_res),
        .o_full (w_res_full),
        .i_pop  (pop),
        .o_data (w_res_data),
        .o_empty(empty)
    );

    assign o_result = tgs_pkg::t_result'(w_res_data);

    `TGS_ASSERT_NEXT(a_request_queued, push && !full, !w_in_empty, "accepted request not queued")
    `TGS_ASSERT_SAME(a_class_needs_end, !empty && (o_result.gesture_class != tgs_pkg::CLS_NONE), o_result.gesture_end, "gesture class without gesture end")
    `TGS_ASSERT_SAME(a_peak_needs_end, !empty && (o_result.peak_fingers != 8'd0), o_result.gesture_end, "peak fingers without gesture end")
    `TGS_ASSERT_SAME(a_end_needs_frame, !empty && o_result.gesture_end, o_result.frame_accepted && (o_result.read_value == 16'd0), "gesture end outside an accepted frame")

endmodule

// File: tb/gesture_stats_checker.sv
// ---------------------------------------------------------------------------
// gesture_stats_checker
// Watches the request, result and register-write channels of the touch
// gesture statistics core and keeps its own model of the gesture state and
// usage counters. The model predicts one result per accepted request, and
// each accepted result is compared field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module gesture_stats_checker #(
    parameter int MAX_FINGERS = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic                          i_full,
    input  tgs_pkg::t_in_item             i_item,
    input  logic                          i_empty,
    input  logic                          i_pop,
    input  tgs_pkg::t_result              i_result,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [tgs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    output int                            o_pending,
    output int                            o_mismatches
);

    localparam int         PRINT_LIMIT = 40;
    // Contact bits that take part in the all-up test; never more than five.
    localparam logic [4:0] SLOT_MASK   = 5'((64'd1 << MAX_FINGERS) - 64'd1);

    logic [31:0]      move_thr;
    logic [15:0]      short_frames;
    logic [15:0]      last_scan;
    logic [15:0]      frames_in_touch;
    logic             key_was_down;
    logic [7:0]       finger_peak;
    logic             lone_finger;
    logic             has_moved;
    logic [15:0]      origin_x;
    logic [15:0]      origin_y;
    logic [15:0]      usage [tgs_pkg::NUM_COUNTERS];
    tgs_pkg::t_result results_due[$];
    int               results_seen = 0;
    int               mismatches   = 0;

    assign o_mismatches = mismatches;

    function automatic void restart_touch();
        last_scan       = '0;
        frames_in_touch = '0;
        key_was_down    = 1'b0;
        finger_peak     = '0;
        lone_finger     = 1'b1;
        has_moved       = 1'b0;
        origin_x        = '0;
        origin_y        = '0;
    endfunction

    // Saturating increment; tells whether the counter now stands at its ceiling.
    function automatic logic bump_usage(input int idx);
        if (usage[idx] != tgs_pkg::CNT_MAX) begin
            usage[idx] = usage[idx] + 16'd1;
        end
        return usage[idx] == tgs_pkg::CNT_MAX;
    endfunction

    function automatic tgs_pkg::t_result step_gesture_stats(input tgs_pkg::t_in_item req);
        tgs_pkg::t_result r;
        longint           dx;
        longint           dy;
        int               peak;
        r = '0;
        case (req.operation)
            tgs_pkg::OP_READ: begin
                if (req.counter_index < tgs_pkg::NUM_COUNTERS) begin
                    r.read_value = usage[req.counter_index];
                end
            end
            tgs_pkg::OP_CLEAR: begin
                foreach (usage[i]) usage[i] = '0;
            end
            tgs_pkg::OP_FRAME: begin
                if (req.scan_time != last_scan) begin
                    r.frame_accepted = 1'b1;
                    last_scan = req.scan_time;
                    if (frames_in_touch != tgs_pkg::CNT_MAX) begin
                        frames_in_touch = frames_in_touch + 16'd1;
                    end
                    if (!req.key_pressed && key_was_down) begin
                        r.overflow_alert |= bump_usage(tgs_pkg::IDX_PRESS);
                    end
                    key_was_down = req.key_pressed;
                    if (req.finger_count > finger_peak) begin
                        finger_peak = req.finger_count;
                    end
                    if (req.finger_count != 8'd1) begin
                        lone_finger = 1'b0;
                    end
                    if (lone_finger) begin
                        if (frames_in_touch == 16'd1) begin
                            origin_x = req.first_x;
                            origin_y = req.first_y;
                        end else if (!has_moved) begin
                            // Exact squared distance; it can exceed 32 bits.
                            dx = longint'(req.first_x) - longint'(origin_x);
                            dy = longint'(req.first_y) - longint'(origin_y);
                            if (dx * dx + dy * dy > longint'(move_thr)) begin
                                has_moved = 1'b1;
                            end
                        end
                    end
                    if ((req.contact_mask & SLOT_MASK) == 5'd0) begin
                        r.gesture_end  = 1'b1;
                        r.peak_fingers = finger_peak;
                        peak = int'(finger_peak);
                        if (peak >= 1 && peak <= MAX_FINGERS && peak <= tgs_pkg::NUM_BINS) begin
                            r.overflow_alert |= bump_usage(peak - 1);
                        end
                        if (lone_finger) begin
                            if (has_moved) begin
                                r.gesture_class = tgs_pkg::CLS_SLIDE;
                                r.overflow_alert |= bump_usage(tgs_pkg::IDX_SLIDE);
                            end else if (frames_in_touch < short_frames) begin
                                r.gesture_class = tgs_pkg::CLS_SHORT;
                                r.overflow_alert |= bump_usage(tgs_pkg::IDX_SHORT);
                            end else begin
                                r.gesture_class = tgs_pkg::CLS_LONG;
                                r.overflow_alert |= bump_usage(tgs_pkg::IDX_LONG);
                            end
                        end
                        restart_touch();
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Printing stops after a while so that a broken block cannot flood the log.
    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_LIMIT) begin
            $display("[%0t] result %0d: %s", $time, results_seen, what);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
        end
    endtask

    always @(posedge i_clk) begin
        tgs_pkg::t_result want;
        if (!i_rst_n) begin
            move_thr     = tgs_pkg::MOVE_THRESHOLD_RST;
            short_frames = tgs_pkg::SHORT_FRAMES_RST;
            restart_touch();
            foreach (usage[i]) usage[i] = '0;
            results_due.delete();
        end else begin
            // A result leaves only after its request has passed the queues, so the
            // order of these two steps within one edge does not matter.
            if (i_pop && !i_empty) begin
                if (results_due.size() == 0) begin
                    report_mismatch("result with no request waiting for it");
                end else begin
                    want = results_due.pop_front();
                    check_field("read_value", i_result.read_value, want.read_value);
                    check_field("frame_accepted", 16'(i_result.frame_accepted),
                                16'(want.frame_accepted));
                    check_field("gesture_end", 16'(i_result.gesture_end),
                                16'(want.gesture_end));
                    check_field("gesture_class", 16'(i_result.gesture_class),
                                16'(want.gesture_class));
                    check_field("peak_fingers", 16'(i_result.peak_fingers),
                                16'(want.peak_fingers));
                    check_field("overflow_alert", 16'(i_result.overflow_alert),
                                16'(want.overflow_alert));
                end
                results_seen++;
            end
            if (i_push && !i_full) begin
                results_due.push_back(step_gesture_stats(i_item));
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    tgs_pkg::CFG_MOVE_THRESHOLD: move_thr     = i_cfg_data;
                    tgs_pkg::CFG_SHORT_FRAMES:   short_frames = i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
        o_pending <= results_due.size();
    end

endmodule

// File: tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Drives touch frames, counter reads and clears into the touch gesture
// statistics core under bursty input and a stalling result side, across
// several threshold settings. Checking is done by the gesture statistics
// checker.
// ---------------------------------------------------------------------------
module testbench;

    localparam int         CLK_PERIOD   = 12;
    localparam int         RESET_CYCLES = 9;
    localparam int         LIMIT_CYCLES = 2_000_000;
    localparam int         LONG_HOLD    = 100;
    localparam logic [1:0] OP_NONE      = 2'd3;

    logic                          i_clk     = 1'b0;
    logic                          i_rst_n   = 1'b0;
    logic                          push      = 1'b0;
    logic                          full;
    tgs_pkg::t_in_item             req_item  = '0;
    logic                          empty;
    logic                          pop       = 1'b0;
    tgs_pkg::t_result              result;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [tgs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]                   cfg_data  = '0;
    int                            pending;
    int                            mismatches;

    // Sender state.
    int                   items_sent = 0;
    int                   burst_left = 0;
    bit                   tx_eager   = 1'b0;
    logic [15:0]          scan_now   = '0;

    // Receiver state; hold_ticket is bumped by the stimulus to ask for a long hold.
    int                   hold_ticket  = 0;
    int                   holds_served = 0;
    int                   hold_left    = 0;
    int                   pattern_left = 0;
    logic [7:0]           stall_pattern = '0;

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    touch_gesture_statistics_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (req_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (result),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    gesture_stats_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_item       (req_item),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_result     (result),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    // Result side: a rotating stall pattern, replaced now and then, with
    // long holds on request.
    always @(posedge i_clk) begin
        logic take;
        if (!i_rst_n) begin
            take = 1'b0;
        end else if (holds_served != hold_ticket) begin
            holds_served = hold_ticket;
            hold_left    = LONG_HOLD;
            take         = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            take = 1'b0;
        end else begin
            if (pattern_left == 0) begin
                pattern_left  = $urandom_range(16, 48);
                // Bit 7 stays clear so that every pattern lets a result through.
                stall_pattern = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom) & 8'h7F;
            end
            pattern_left--;
            take          = ~stall_pattern[0];
            stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
        end
        pop <= take;
    end

    function automatic tgs_pkg::t_in_item random_item();
        tgs_pkg::t_in_item it;
        it.operation     = 2'($urandom);
        it.scan_time     = 16'($urandom);
        it.key_pressed   = 1'($urandom);
        it.finger_count  = 8'($urandom);
        it.first_x       = 16'($urandom);
        it.first_y       = 16'($urandom);
        it.contact_mask  = 5'($urandom);
        it.counter_index = 4'($urandom);
        return it;
    endfunction

    // Offers one request and returns at the edge that accepts it.
    task automatic offer(input tgs_pkg::t_in_item it);
        if (!tx_eager) begin
            if (burst_left == 0) begin
                push <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                        : $urandom_range(1, 12);
            end
            burst_left--;
        end
        push     <= 1'b1;
        req_item <= it;
        do @(posedge i_clk); while (full);
        items_sent++;
    endtask

    task automatic send_frame(input logic [15:0] scan, input logic key,
                              input logic [7:0] fingers, input logic [15:0] x,
                              input logic [15:0] y, input logic [4:0] mask);
        tgs_pkg::t_in_item it;
        it              = random_item();
        it.operation    = tgs_pkg::OP_FRAME;
        it.scan_time    = scan;
        it.key_pressed  = key;
        it.finger_count = fingers;
        it.first_x      = x;
        it.first_y      = y;
        it.contact_mask = mask;
        offer(it);
    endtask

    task automatic send_other(input logic [1:0] op, input logic [3:0] idx);
        tgs_pkg::t_in_item it;
        it               = random_item();
        it.operation     = op;
        it.counter_index = idx;
        offer(it);
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 19))
            0, 1, 2:    send_other(tgs_pkg::OP_CLEAR, 4'($urandom));
            3, 4, 5, 6: send_other(OP_NONE, 4'($urandom));
            default:    send_other(tgs_pkg::OP_READ, 4'($urandom));
        endcase
    endtask

    // One touch from first contact to all-up, with random content and the
    // odd repeated scan time, stray finger count or interleaved request.
    task automatic play_gesture(input int len);
        tgs_pkg::t_in_item it;
        logic [15:0]       x;
        logic [15:0]       y;
        logic              key;
        int                shape;
        int                stride;
        int                n;
        shape = $urandom_range(0, 9);
        case ($urandom_range(0, 4))
            0:       stride = 0;
            1:       stride = 3;
            2:       stride = 60;
            3:       stride = 300;
            default: stride = 30000;
        endcase
        case ($urandom_range(0, 7))
            0:       x = '0;
            1:       x = '1;
            default: x = 16'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0:       y = '0;
            1:       y = '1;
            default: y = 16'($urandom);
        endcase
        key      = 1'($urandom);
        scan_now = 16'($urandom);
        for (n = 0; n < len; n++) begin
            it           = random_item();
            it.operation = tgs_pkg::OP_FRAME;
            if (n == 0 && $urandom_range(0, 19) == 0) begin
                it.scan_time = '0;
            end else if (n > 0 && $urandom_range(0, 15) == 0) begin
                it.scan_time = scan_now;
            end else begin
                scan_now     = scan_now + 16'($urandom_range(1, 5));
                it.scan_time = scan_now;
            end
            if ($urandom_range(0, 2) == 0) begin
                key = ~key;
            end
            it.key_pressed = key;
            case (shape)
                6, 7:    it.finger_count = 8'($urandom_range(2, 5));
                8:       it.finger_count = (n == len / 2) ? 8'($urandom_range(0, 5)) : 8'd1;
                9:       it.finger_count = 8'($urandom);
                default: it.finger_count = 8'd1;
            endcase
            x = x + 16'($urandom_range(0, 2 * stride)) - 16'(stride);
            y = y + 16'($urandom_range(0, 2 * stride)) - 16'(stride);
            it.first_x      = x;
            it.first_y      = y;
            it.contact_mask = (n == len - 1) ? 5'd0 : 5'($urandom_range(1, 31));
            offer(it);
            if ($urandom_range(0, 11) == 0) begin
                send_noise();
            end
        end
    endtask

    task automatic run_gestures(input int quota);
        int start;
        start = items_sent;
        while (items_sent - start < quota) begin
            play_gesture(($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12));
        end
    endtask

    // The receiver holds off while the sender keeps going, so the block fills.
    task automatic starve_receiver();
        hold_ticket <= hold_ticket + 1;
        tx_eager = 1'b1;
        run_gestures(24);
        tx_eager = 1'b0;
    endtask

    task automatic drain();
        push <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Writes both registers back to back; the upper data bits of the frame
    // limit are random and must be ignored.
    task automatic load_config(input logic [31:0] thr, input logic [15:0] frames);
        cfg_valid <= 1'b1;
        cfg_index <= tgs_pkg::CFG_MOVE_THRESHOLD;
        cfg_data  <= thr;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_index <= tgs_pkg::CFG_SHORT_FRAMES;
        cfg_data  <= {16'($urandom), frames};
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int i;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset settings. A scan time of zero right
        // after reset matches the cleared last scan time and is dropped.
        send_frame(16'd0, 1'b0, 8'd1, 16'd100, 16'd100, 5'd1);
        send_other(OP_NONE, 4'd0);
        send_frame(16'd1, 1'b1, 8'd1, 16'd0, 16'd0, 5'd1);
        send_frame(16'd2, 1'b0, 8'd1, 16'hFFFF, 16'hFFFF, 5'd1);
        send_frame(16'd2, 1'b1, 8'd1, 16'd0, 16'd0, 5'd0);
        send_frame(16'd3, 1'b0, 8'd1, 16'hFFFF, 16'hFFFF, 5'd0);
        // Squared distance exactly at the threshold is not a move.
        send_frame(16'd4, 1'b0, 8'd1, 16'd500, 16'd500, 5'd1);
        send_frame(16'd5, 1'b0, 8'd1, 16'd600, 16'd600, 5'd0);
        send_frame(16'd6, 1'b0, 8'd1, 16'd500, 16'd500, 5'd1);
        send_frame(16'd7, 1'b0, 8'd1, 16'd600, 16'd601, 5'd0);
        // Peak above the bin range, a zero peak, and the top bin.
        send_frame(16'd8, 1'b1, 8'd255, 16'd1, 16'd2, 5'h1F);
        send_frame(16'd9, 1'b0, 8'd3, 16'd3, 16'd4, 5'd0);
        send_frame(16'd10, 1'b0, 8'd0, 16'd0, 16'd0, 5'd0);
        send_frame(16'd11, 1'b0, 8'd5, 16'd7, 16'd7, 5'h10);
        send_frame(16'd12, 1'b0, 8'd2, 16'd7, 16'd7, 5'd0);
        for (i = 0; i < tgs_pkg::NUM_COUNTERS; i++) begin
            send_other(tgs_pkg::OP_READ, 4'(i));
        end
        send_other(tgs_pkg::OP_READ, '1);
        send_other(tgs_pkg::OP_CLEAR, 4'd0);
        send_frame(16'hFFFF, 1'b1, 8'd1, 16'd9, 16'd9, 5'd0);
        send_other(tgs_pkg::OP_READ, 4'(tgs_pkg::IDX_SHORT));

        drain();
        load_config(32'd0, 16'd3);
        run_gestures(150);

        drain();
        load_config(32'hFFFF_FFFF, 16'hFFFF);
        run_gestures(70);
        starve_receiver();
        run_gestures(60);

        drain();
        load_config(32'($urandom_range(0, 50000)), 16'd0);
        run_gestures(60);
        drain();
        run_gestures(60);
        starve_receiver();

        drain();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #(longint'(LIMIT_CYCLES) * CLK_PERIOD);
        $display("Regression FAIL");
        $finish;
    end

endmodule
